@@ hw/rtl/twpc_pkg.sv @@
package twpc_pkg;

  // neighbours per window, in circular order from north, clockwise
  localparam int NBR_COUNT = 8;

  localparam int THRESH_W   = 32;
  localparam int CLASS_W    = 5;
  localparam int OUT_TDATA_W = 8;

  localparam logic signed [THRESH_W-1:0] THRESH_RESET = 32'sd256;

  // class codes
  localparam logic signed [CLASS_W-1:0] CLASS_NONE    = 5'sd0;
  localparam logic signed [CLASS_W-1:0] CLASS_PEAK    = 5'sd9;
  localparam logic signed [CLASS_W-1:0] CLASS_PIT     = -5'sd9;
  localparam logic signed [CLASS_W-1:0] CLASS_PASS    = 5'sd1;
  localparam logic signed [CLASS_W-1:0] CLASS_CONVEX  = 5'sd2;
  localparam logic signed [CLASS_W-1:0] CLASS_CONCAVE = -5'sd2;
  localparam logic signed [CLASS_W-1:0] CLASS_RIDGE   = 5'sd7;
  localparam logic signed [CLASS_W-1:0] CLASS_CHANNEL = -5'sd7;

  localparam int COUNT_W = 4;

  // sign-change counts and break run length that select a class
  localparam logic [COUNT_W-1:0] SIGN_CHANGES_PASS = 4'd4;
  localparam logic [COUNT_W-1:0] SIGN_CHANGES_LINE = 4'd2;
  localparam logic [COUNT_W-1:0] RUN_LEN_BREAK     = 4'd4;

  // shape of the window as seen by the classifier
  typedef struct packed {
    logic               missing;
    logic [COUNT_W-1:0] sign_changes;
    logic [COUNT_W-1:0] run_len;
  } twpc_shape_t;

endpackage

@@ hw/rtl/twpc_stats_stage.sv @@
module twpc_stats_stage #(
  parameter int HEIGHT_BITS = 32
) (
  input  logic                                             clk,
  input  logic                                             en,
  input  logic [HEIGHT_BITS-1:0]                           centre,
  input  logic                                             centre_missing,
  input  logic [twpc_pkg::NBR_COUNT-1:0][HEIGHT_BITS-1:0]  nbr,
  input  logic [twpc_pkg::NBR_COUNT-1:0]                   inside_mask,
  output logic [HEIGHT_BITS+2:0]                           dplus_r,
  output logic [HEIGHT_BITS+2:0]                           dminus_r,
  output twpc_pkg::twpc_shape_t                            shape_r
);
  import twpc_pkg::*;

  localparam int DW = HEIGHT_BITS + 1;

  logic [NBR_COUNT-1:0][DW-1:0]          diff;
  logic [NBR_COUNT-1:0]                  gt;
  logic [NBR_COUNT-1:0]                  lt;
  logic [NBR_COUNT-1:0][HEIGHT_BITS-1:0] rise;
  logic [NBR_COUNT-1:0][HEIGHT_BITS-1:0] fall;

  logic [3:0][HEIGHT_BITS:0]   rise_l1;
  logic [3:0][HEIGHT_BITS:0]   fall_l1;
  logic [1:0][HEIGHT_BITS+1:0] rise_l2;
  logic [1:0][HEIGHT_BITS+1:0] fall_l2;
  logic [HEIGHT_BITS+2:0]      dplus_nxt;
  logic [HEIGHT_BITS+2:0]      dminus_nxt;
  twpc_shape_t                 shape_nxt;

  // differences against the centre, off-grid neighbours read as the centre
  always_comb begin
    logic [HEIGHT_BITS-1:0] alt;
    logic [DW-1:0]          neg;
    for (int k = 0; k < NBR_COUNT; k++) begin
      alt     = inside_mask[k] ? nbr[k] : centre;
      diff[k] = {alt[HEIGHT_BITS-1], alt} - {centre[HEIGHT_BITS-1], centre};
      neg     = '0 - diff[k];
      lt[k]   = diff[k][DW-1];
      gt[k]   = ~diff[k][DW-1] & (|diff[k][DW-2:0]);
      rise[k] = gt[k] ? diff[k][HEIGHT_BITS-1:0] : '0;
      fall[k] = lt[k] ? neg[HEIGHT_BITS-1:0] : '0;
    end
  end

  // adder trees for rises and falls
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rise_l1[j] = {1'b0, rise[2*j]} + {1'b0, rise[2*j+1]};
      fall_l1[j] = {1'b0, fall[2*j]} + {1'b0, fall[2*j+1]};
    end
    for (int j = 0; j < 2; j++) begin
      rise_l2[j] = {1'b0, rise_l1[2*j]} + {1'b0, rise_l1[2*j+1]};
      fall_l2[j] = {1'b0, fall_l1[2*j]} + {1'b0, fall_l1[2*j+1]};
    end
    dplus_nxt  = {1'b0, rise_l2[0]} + {1'b0, rise_l2[1]};
    dminus_nxt = {1'b0, fall_l2[0]} + {1'b0, fall_l2[1]};
  end

  // circular sign changes and the run after the first run
  always_comb begin
    logic               above;
    logic               hi7;
    logic               skipping;
    logic               counting;
    logic [COUNT_W-1:0] changes;
    logic [COUNT_W-1:0] run;
    above    = gt[NBR_COUNT-1];
    hi7      = gt[NBR_COUNT-1];
    changes  = '0;
    skipping = 1'b1;
    counting = 1'b0;
    run      = '0;
    for (int k = 0; k < NBR_COUNT; k++) begin
      if (gt[k] && !above) begin
        changes = changes + 4'd1;
        above   = 1'b1;
      end else if (lt[k] && above) begin
        changes = changes + 4'd1;
        above   = 1'b0;
      end
      if (skipping) begin
        if (!(hi7 ? gt[k] : lt[k])) begin
          skipping = 1'b0;
          counting = 1'b1;
          run      = 4'd1;
        end
      end else if (counting) begin
        if (hi7 ? lt[k] : gt[k]) begin
          run = run + 4'd1;
        end else begin
          counting = 1'b0;
        end
      end
    end
    shape_nxt.missing      = centre_missing;
    shape_nxt.sign_changes = changes;
    shape_nxt.run_len      = run;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dplus_r  <= dplus_nxt;
      dminus_r <= dminus_nxt;
      shape_r  <= shape_nxt;
    end
  end

endmodule

@@ hw/rtl/twpc_classify_stage.sv @@
module twpc_classify_stage #(
  parameter int HEIGHT_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic [HEIGHT_BITS+2:0]                    dplus,
  input  logic [HEIGHT_BITS+2:0]                    dminus,
  input  twpc_pkg::twpc_shape_t                     shape,
  input  logic signed [twpc_pkg::THRESH_W-1:0]      threshold,
  output logic signed [twpc_pkg::CLASS_W-1:0]       class_r,
  output logic                                      missing_r
);
  import twpc_pkg::*;

  localparam int CW = (HEIGHT_BITS + 4 > THRESH_W) ? HEIGHT_BITS + 4 : THRESH_W;

  logic signed [CW-1:0]      dplus_x;
  logic signed [CW-1:0]      dminus_x;
  logic signed [CW-1:0]      thr_x;
  logic signed [CW-1:0]      fall_excess;
  logic signed [CW-1:0]      rise_excess;
  logic signed [CLASS_W-1:0] class_nxt;

  assign dplus_x     = signed'(CW'(dplus));
  assign dminus_x    = signed'(CW'(dminus));
  assign thr_x       = CW'(threshold);
  assign fall_excess = dminus_x - dplus_x;
  assign rise_excess = dplus_x - dminus_x;

  always_comb begin
    class_nxt = CLASS_NONE;
    if (shape.missing) begin
      class_nxt = CLASS_NONE;
    end else if (dplus == '0) begin
      class_nxt = CLASS_PEAK;
    end else if (dminus == '0) begin
      class_nxt = CLASS_PIT;
    end else if (shape.sign_changes == SIGN_CHANGES_PASS) begin
      class_nxt = CLASS_PASS;
    end else if (shape.sign_changes == SIGN_CHANGES_LINE) begin
      if (shape.run_len == RUN_LEN_BREAK) begin
        if (fall_excess > thr_x) begin
          class_nxt = CLASS_CONVEX;
        end else if (rise_excess > thr_x) begin
          class_nxt = CLASS_CONCAVE;
        end else begin
          class_nxt = CLASS_NONE;
        end
      end else begin
        class_nxt = (fall_excess > 0) ? CLASS_RIDGE : CLASS_CHANNEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      class_r   <= class_nxt;
      missing_r <= shape.missing;
    end
  end

endmodule

@@ hw/rtl/terrain_window_point_classifier_top.sv @@
// terrain window point classifier
//
// in channel: one 3x3 elevation window per word. in_tdata carries the centre
// height, the eight neighbour heights (north first, clockwise) and the
// inside-grid mask; in_tuser flags a no-data centre.
// out channel: one class per window, in input order. out_tdata holds the
// signed class code, out_tuser flags a no-data result.
// cfg port: one write-only register, the break threshold; the user writes it by
// cfg_wr_en / cfg_wr_data only while the block is idle, the block does not check.
//
// three register stages: input register, window statistics (differences,
// rise/fall adder trees, sign changes, run length) and the result register.
// an accepted word moves through the input, statistics and result registers in turn.
// one word per cycle is sustained while out_tready is high; the rate is set by the
// single pass through the statistics and classification logic, each stage fully
// registered. when out_tready is low the stages fill up behind the result register
// and in_tready drops only once all three hold a word; nothing is lost or repeated.
// reset empties all stages and loads the threshold with its default of 256
module terrain_window_point_classifier_top #(
  parameter int HEIGHT_BITS = 32,
  localparam int IN_FIELD_W = (twpc_pkg::NBR_COUNT + 1) * HEIGHT_BITS + twpc_pkg::NBR_COUNT,
  localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in channel
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // centre_height, height_dir0 .. height_dir7, inside_mask, zero pad
  input  logic [IN_TDATA_W-1:0]                  in_tdata,
  // centre_missing
  input  logic                                   in_tuser,
  // out channel
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // point_class, zero pad
  output logic [twpc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // result_missing
  output logic                                   out_tuser,
  // configuration
  input  logic                                   cfg_wr_en,
  input  logic [twpc_pkg::THRESH_W-1:0]          cfg_wr_data
);
  import twpc_pkg::*;

  // handshake and stage occupancy
  logic v0_r, v0_nxt;
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic ready0, ready1, ready2;

  // break threshold register
  logic signed [THRESH_W-1:0] thr_r;

  // input register payload
  logic [HEIGHT_BITS-1:0]                  centre_r;
  logic                                    cmiss_r;
  logic [NBR_COUNT-1:0][HEIGHT_BITS-1:0]   nbr_r;
  logic [NBR_COUNT-1:0]                    mask_r;

  logic [HEIGHT_BITS-1:0]                  in_centre;
  logic [NBR_COUNT-1:0][HEIGHT_BITS-1:0]   in_nbr;
  logic [NBR_COUNT-1:0]                    in_mask;

  // statistics stage
  logic [HEIGHT_BITS+2:0] dplus_r;
  logic [HEIGHT_BITS+2:0] dminus_r;
  twpc_shape_t            shape_r;

  // result register
  logic signed [CLASS_W-1:0] class_r;
  logic                      res_missing_r;

  // unpack the in word, first field in the lowest bits
  assign in_centre = in_tdata[HEIGHT_BITS-1:0];
  always_comb begin
    for (int k = 0; k < NBR_COUNT; k++) begin
      in_nbr[k] = in_tdata[(k + 1) * HEIGHT_BITS +: HEIGHT_BITS];
    end
  end
  assign in_mask = in_tdata[(NBR_COUNT + 1) * HEIGHT_BITS +: NBR_COUNT];

  // a stage may load when it is empty or the one after it moves on
  assign ready2    = !v2_r || out_tready;
  assign ready1    = !v1_r || ready2;
  assign ready0    = !v0_r || ready1;
  assign in_tready = ready0;

  assign v0_nxt = ready0 ? in_tvalid : v0_r;
  assign v1_nxt = ready1 ? v0_r : v1_r;
  assign v2_nxt = ready2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      thr_r <= THRESH_RESET;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      if (cfg_wr_en) begin
        thr_r <= signed'(cfg_wr_data);
      end
    end
  end

  // input register, payload only
  always_ff @(posedge clk) begin
    if (ready0 && in_tvalid) begin
      centre_r <= in_centre;
      cmiss_r  <= in_tuser;
      nbr_r    <= in_nbr;
      mask_r   <= in_mask;
    end
  end

  twpc_stats_stage #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_stats (
    .clk            (clk),
    .en             (ready1),
    .centre         (centre_r),
    .centre_missing (cmiss_r),
    .nbr            (nbr_r),
    .inside_mask    (mask_r),
    .dplus_r        (dplus_r),
    .dminus_r       (dminus_r),
    .shape_r        (shape_r)
  );

  twpc_classify_stage #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_classify (
    .clk       (clk),
    .en        (ready2),
    .dplus     (dplus_r),
    .dminus    (dminus_r),
    .shape     (shape_r),
    .threshold (thr_r),
    .class_r   (class_r),
    .missing_r (res_missing_r)
  );

  assign out_tvalid = v2_r;
  assign out_tdata  = {{(OUT_TDATA_W - CLASS_W){1'b0}}, class_r};
  assign out_tuser  = res_missing_r;

  // a no-data result always carries the empty class
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> class_r == CLASS_NONE)
    else $error("no-data result with a class");

  // every delivered class is one of the defined codes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (class_r == CLASS_NONE || class_r == CLASS_PEAK ||
                    class_r == CLASS_PIT || class_r == CLASS_PASS ||
                    class_r == CLASS_CONVEX || class_r == CLASS_CONCAVE ||
                    class_r == CLASS_RIDGE || class_r == CLASS_CHANNEL))
    else $error("undefined class code");

  // back-pressure reaches the in channel only with every stage full
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v0_r && v1_r && v2_r && !out_tready)
    else $error("in channel stalled with a free stage");

  // pipeline is empty straight after reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !v0_r && !v1_r && !v2_r)
    else $error("stage occupied after reset");

  // a held result moves on only when it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && !out_tready |=> v1_r && v2_r)
    else $error("word dropped under back-pressure");

endmodule
